// ===== rtl/mpq_pkg.sv =====
// ----------------------------------------------------------------------------
// mpq_pkg
// Shared types, field widths, action codes and the entry ordering function
// of the three-key min-priority queue.
// ----------------------------------------------------------------------------
package mpq_pkg;

  // default sizing
  localparam int CAPACITY_DEF   = 4096;
  localparam int COORD_BITS_DEF = 8;

  // fixed field widths
  localparam int COUNT_W     = 9;
  localparam int KEY_W       = 32;
  localparam int FILL_W      = 13;
  localparam int COORD_OUT_W = 8;
  localparam int CMP_COORD_W = 16;

  // action codes
  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  // pushes below this count are dropped
  localparam logic [COUNT_W-1:0] MIN_KEEP_COUNT = 9'd2;

  typedef struct packed {
    logic                   action;
    logic [COORD_OUT_W-1:0] pos_x;
    logic [COORD_OUT_W-1:0] pos_y;
    logic [COUNT_W-1:0]     option_count;
    logic [KEY_W-1:0]       random_key;
  } in_item_t;

  typedef struct packed {
    logic                   valid_res;
    logic [COORD_OUT_W-1:0] out_x;
    logic [COORD_OUT_W-1:0] out_y;
    logic [COUNT_W-1:0]     out_count;
    logic [KEY_W-1:0]       out_key;
    logic [FILL_W-1:0]      fill_level;
    logic                   is_empty;
    logic                   overflow;
  } out_item_t;

  // true when entry a orders strictly ahead of entry b
  function automatic logic entry_before(
    input logic [COUNT_W-1:0]     cnt_a,
    input logic [KEY_W-1:0]       key_a,
    input logic [CMP_COORD_W-1:0] x_a,
    input logic [CMP_COORD_W-1:0] y_a,
    input logic [COUNT_W-1:0]     cnt_b,
    input logic [KEY_W-1:0]       key_b,
    input logic [CMP_COORD_W-1:0] x_b,
    input logic [CMP_COORD_W-1:0] y_b
  );
    logic res;
    if (cnt_a != cnt_b) begin
      res = (cnt_a < cnt_b);
    end else if (key_a != key_b) begin
      res = (key_a < key_b);
    end else if (x_a != x_b) begin
      res = (x_a < x_b);
    end else begin
      res = (y_a < y_b);
    end
    return res;
  endfunction

endpackage

// ===== rtl/min_priority_queue_three_key.sv =====
// ----------------------------------------------------------------------------
// min_priority_queue_three_key
// Min-priority queue of grid cells kept as a binary heap in one memory,
// ordered by option count, random key, column and row.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake                 payload
//   in        input       in_valid_i / in_stall_o   in_item_i  (in_item_t)
//   out       output      out_valid_o / out_stall_i out_item_o (out_item_t)
//
// one item at a time; each heap level walked takes a memory read state, then a
// compare and write back state, plus states for accept, root load on a pop and result
// dropped pushes, full pushes and empty pops go straight from accept to result
// reset empties the queue at once; heap memory is not cleared
// a result waits in the output register while the next item is worked on
//
module min_priority_queue_three_key
  import mpq_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int ENT_W = 2 * COORD_BITS + COUNT_W + KEY_W;
  localparam int IDX_W = $clog2(CAPACITY);

  logic             res_valid, res_take;
  out_item_t        res_item;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr_a, ram_raddr_b;
  logic [ENT_W-1:0] ram_wdata, ram_rdata_a, ram_rdata_b;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_item_q;

  mpq_ctrl #(
    .CAPACITY  (CAPACITY),
    .COORD_BITS(COORD_BITS),
    .ENT_W     (ENT_W),
    .IDX_W     (IDX_W)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_item_i    (in_item_i),
    .res_valid_o  (res_valid),
    .res_take_i   (res_take),
    .res_item_o   (res_item),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_raddr_a_o(ram_raddr_a),
    .ram_raddr_b_o(ram_raddr_b),
    .ram_rdata_a_i(ram_rdata_a),
    .ram_rdata_b_i(ram_rdata_b)
  );

  mpq_heap_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (ENT_W),
    .ADDR_W(IDX_W)
  ) u_ram (
    .clk_i    (clk_i),
    .we_i     (ram_we),
    .waddr_i  (ram_waddr),
    .wdata_i  (ram_wdata),
    .raddr_a_i(ram_raddr_a),
    .raddr_b_i(ram_raddr_b),
    .rdata_a_o(ram_rdata_a),
    .rdata_b_o(ram_rdata_b)
  );

  // output register, loads when empty or being drained
  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_take) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_item_q <= res_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== rtl/mpq_heap_ram.sv =====
// ----------------------------------------------------------------------------
// mpq_heap_ram
// Heap storage: one write port and two read ports, registered read data.
// ----------------------------------------------------------------------------
module mpq_heap_ram #(
  parameter int DEPTH  = 4096,
  parameter int WIDTH  = 57,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_a_i,
  input  logic [ADDR_W-1:0] raddr_b_i,
  output logic [WIDTH-1:0]  rdata_a_o,
  output logic [WIDTH-1:0]  rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // two read ports, registered read data
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ===== rtl/mpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// mpq_ctrl
// Heap sequencer: takes one item, walks sift up or sift down over the heap
// memory as the item needs, with a held entry and a moving hole, then offers one result.
// ----------------------------------------------------------------------------
module mpq_ctrl
  import mpq_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int ENT_W      = 2 * COORD_BITS + COUNT_W + KEY_W,
  parameter int IDX_W      = $clog2(CAPACITY)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // item side
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_item_i,
  // result side
  output logic             res_valid_o,
  input  logic             res_take_i,
  output out_item_t        res_item_o,
  // heap memory
  output logic             ram_we_o,
  output logic [IDX_W-1:0] ram_waddr_o,
  output logic [ENT_W-1:0] ram_wdata_o,
  output logic [IDX_W-1:0] ram_raddr_a_o,
  output logic [IDX_W-1:0] ram_raddr_b_o,
  input  logic [ENT_W-1:0] ram_rdata_a_i,
  input  logic [ENT_W-1:0] ram_rdata_b_i
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IW    = IDX_W + 2;
  localparam int KEY_LO = 0;
  localparam int CNT_LO = KEY_W;
  localparam int Y_LO   = KEY_W + COUNT_W;
  localparam int X_LO   = Y_LO + COORD_BITS;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_UP_RD  = 3'd1;
  localparam logic [2:0] ST_UP_CMP = 3'd2;
  localparam logic [2:0] ST_POP_LD = 3'd3;
  localparam logic [2:0] ST_DN_RD  = 3'd4;
  localparam logic [2:0] ST_DN_CMP = 3'd5;
  localparam logic [2:0] ST_DONE   = 3'd6;

  function automatic logic ent_before(input logic [ENT_W-1:0] a, input logic [ENT_W-1:0] b);
    return entry_before(a[CNT_LO+:COUNT_W], a[KEY_LO+:KEY_W],
                        CMP_COORD_W'(a[X_LO+:COORD_BITS]), CMP_COORD_W'(a[Y_LO+:COORD_BITS]),
                        b[CNT_LO+:COUNT_W], b[KEY_LO+:KEY_W],
                        CMP_COORD_W'(b[X_LO+:COORD_BITS]), CMP_COORD_W'(b[Y_LO+:COORD_BITS]));
  endfunction

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pop_ok_q, pop_ok_d;
  logic             ovf_q, ovf_d;
  logic [IDX_W-1:0] hole_q, hole_d;
  logic [ENT_W-1:0] held_q, held_d;
  logic [ENT_W-1:0] top_q, top_d;

  logic             in_acc;
  logic [ENT_W-1:0] push_ent;
  logic             is_full;
  logic [IDX_W-1:0] last_idx;
  logic [IDX_W-1:0] parent_idx;
  logic [IW-1:0]    lchild_w, rchild_w, cnt_w;
  logic             l_ok, r_ok;
  logic             l_lt_h, r_lt_h, r_lt_l, pick_l, pick_r;

  // index arithmetic around the hole
  assign last_idx   = IDX_W'(cnt_q - CNT_W'(1));
  assign parent_idx = IDX_W'((hole_q - IDX_W'(1)) >> 1);
  assign lchild_w   = IW'({hole_q, 1'b1});
  assign rchild_w   = lchild_w + IW'(1);
  assign cnt_w      = IW'(cnt_q);
  assign l_ok       = (lchild_w < cnt_w);
  assign r_ok       = (rchild_w < cnt_w);

  // child selection, three compares in parallel
  assign l_lt_h = ent_before(ram_rdata_a_i, held_q);
  assign r_lt_h = ent_before(ram_rdata_b_i, held_q);
  assign r_lt_l = ent_before(ram_rdata_b_i, ram_rdata_a_i);
  assign pick_r = r_ok && (l_lt_h ? r_lt_l : r_lt_h);
  assign pick_l = !pick_r && l_lt_h;

  assign in_acc     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign is_full    = (cnt_q == CNT_W'(CAPACITY));
  assign push_ent   = {COORD_BITS'(in_item_i.pos_x), COORD_BITS'(in_item_i.pos_y),
                       in_item_i.option_count, in_item_i.random_key};

  // sequencer
  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    pop_ok_d      = pop_ok_q;
    ovf_d         = ovf_q;
    hole_d        = hole_q;
    held_d        = held_q;
    top_d         = top_q;
    ram_we_o      = 1'b0;
    ram_waddr_o   = hole_q;
    ram_wdata_o   = held_q;
    ram_raddr_a_o = '0;
    ram_raddr_b_o = last_idx;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          pop_ok_d = 1'b0;
          ovf_d    = 1'b0;
          state_d  = ST_DONE;
          if (in_item_i.action == ACT_PUSH) begin
            if (in_item_i.option_count >= MIN_KEEP_COUNT) begin
              if (is_full) begin
                ovf_d = 1'b1;
              end else begin
                held_d  = push_ent;
                hole_d  = IDX_W'(cnt_q);
                cnt_d   = cnt_q + CNT_W'(1);
                state_d = ST_UP_RD;
              end
            end
          end else if (cnt_q != '0) begin
            // root and last entry are being read now
            pop_ok_d = 1'b1;
            cnt_d    = cnt_q - CNT_W'(1);
            state_d  = ST_POP_LD;
          end
        end
      end
      ST_UP_RD: begin
        if (hole_q == '0) begin
          ram_we_o = 1'b1;
          state_d  = ST_DONE;
        end else begin
          ram_raddr_a_o = parent_idx;
          state_d       = ST_UP_CMP;
        end
      end
      ST_UP_CMP: begin
        ram_we_o = 1'b1;
        if (ent_before(held_q, ram_rdata_a_i)) begin
          ram_wdata_o = ram_rdata_a_i;
          hole_d      = parent_idx;
          state_d     = ST_UP_RD;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_POP_LD: begin
        top_d  = ram_rdata_a_i;
        held_d = ram_rdata_b_i;
        hole_d = '0;
        state_d = (cnt_q == '0) ? ST_DONE : ST_DN_RD;
      end
      ST_DN_RD: begin
        if (!l_ok) begin
          ram_we_o = 1'b1;
          state_d  = ST_DONE;
        end else begin
          ram_raddr_a_o = lchild_w[IDX_W-1:0];
          ram_raddr_b_o = rchild_w[IDX_W-1:0];
          state_d       = ST_DN_CMP;
        end
      end
      ST_DN_CMP: begin
        ram_we_o = 1'b1;
        if (pick_r) begin
          ram_wdata_o = ram_rdata_b_i;
          hole_d      = rchild_w[IDX_W-1:0];
          state_d     = ST_DN_RD;
        end else if (pick_l) begin
          ram_wdata_o = ram_rdata_a_i;
          hole_d      = lchild_w[IDX_W-1:0];
          state_d     = ST_DN_RD;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // result item
  always_comb begin
    res_valid_o           = (state_q == ST_DONE);
    res_item_o.valid_res  = pop_ok_q;
    res_item_o.out_x      = pop_ok_q ? COORD_OUT_W'(top_q[X_LO+:COORD_BITS]) : '0;
    res_item_o.out_y      = pop_ok_q ? COORD_OUT_W'(top_q[Y_LO+:COORD_BITS]) : '0;
    res_item_o.out_count  = pop_ok_q ? top_q[CNT_LO+:COUNT_W] : '0;
    res_item_o.out_key    = pop_ok_q ? top_q[KEY_LO+:KEY_W] : '0;
    res_item_o.fill_level = FILL_W'(cnt_q);
    res_item_o.is_empty   = (cnt_q == '0);
    res_item_o.overflow   = ovf_q;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      pop_ok_q <= 1'b0;
      ovf_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      pop_ok_q <= pop_ok_d;
      ovf_q    <= ovf_d;
    end
  end

  // hole index and entries
  always_ff @(posedge clk_i) begin
    hole_q <= hole_d;
    held_q <= held_d;
    top_q  <= top_d;
  end

endmodule

// ===== rtl/mpq_checker.sv =====
// ----------------------------------------------------------------------------
// mpq_checker
// Port-level checks on the result channel of the priority queue.
// ----------------------------------------------------------------------------
module mpq_checker
  import mpq_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // items without a popped entry carry zero entry fields
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.valid_res |->
      out_item_o.out_x == '0 && out_item_o.out_y == '0 &&
      out_item_o.out_count == '0 && out_item_o.out_key == '0)
    else $error("entry fields set on an item with no popped entry");

  // an empty queue reports a zero fill level
  a_empty_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.is_empty |-> out_item_o.fill_level == '0)
    else $error("empty queue with nonzero fill level");

  // overflow only comes from a push, never with a popped entry
  a_ovf_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.overflow |-> !out_item_o.valid_res)
    else $error("overflow flagged on a pop");

  // only counts above one are ever stored, so popped ones are too
  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.valid_res |->
      out_item_o.out_count >= MIN_KEEP_COUNT)
    else $error("popped entry with a count that is never stored");

endmodule

bind min_priority_queue_three_key mpq_checker u_mpq_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_item_o (out_item_o)
);

// ===== test/tb_min_priority_queue_three_key.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_min_priority_queue_three_key
// Self-checking bench for the three-key min-priority queue. A driver feeds
// push and pop items from a pending queue. A monitor checks each result
// against a sorted shadow of the queue contents. The stimulus has three
// parts: directed corner items, a deep fill that is then drained past
// empty, and a long random mix. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_min_priority_queue_three_key;
  import mpq_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 2_000_000;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned FILL_ITEMS   = 500;
  localparam int unsigned RANDOM_ITEMS = 1000;
  localparam int unsigned REPORT_MAX   = 10;

  // sort rank of a held entry: count, key, column, row from most significant
  typedef logic [COUNT_W+KEY_W+2*COORD_OUT_W-1:0] rank_t;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_item_o;

  in_item_t    pending_q[$];
  out_item_t   expected_q[$];
  rank_t       held_q[$];
  int unsigned cycle_cnt    = 0;
  int unsigned mismatch_cnt = 0;
  bit          in_taken     = 1'b0;

  min_priority_queue_three_key dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // cycle count and timeout
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // random idle decision, with a quiet window free of idling
  function automatic bit idle_roll();
    if ((cycle_cnt % 30000) >= 24000) begin
      return 1'b0;
    end
    return ($urandom_range(0, 99) < 19);
  endfunction

  // shadow queue kept sorted, smallest entry at the front
  function automatic out_item_t queue_step(in_item_t it);
    out_item_t res;
    rank_t     ent;
    int        lo;
    int        hi;
    int        mid;
    res = '0;
    if (it.action == ACT_PUSH) begin
      ent = {it.option_count, it.random_key, it.pos_x, it.pos_y};
      if (it.option_count >= MIN_KEEP_COUNT) begin
        if (held_q.size() >= CAPACITY_DEF) begin
          res.overflow = 1'b1;
        end else begin
          // upper bound search keeps equal entries together
          lo = 0;
          hi = held_q.size();
          while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (held_q[mid] <= ent) begin
              lo = mid + 1;
            end else begin
              hi = mid;
            end
          end
          held_q.insert(lo, ent);
        end
      end
    end else if (held_q.size() > 0) begin
      ent = held_q.pop_front();
      res.valid_res = 1'b1;
      {res.out_count, res.out_key, res.out_x, res.out_y} = ent;
    end
    res.fill_level = FILL_W'(held_q.size());
    res.is_empty   = (held_q.size() == 0);
    return res;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatch_cnt++;
      if (mismatch_cnt <= REPORT_MAX) begin
        $display("mismatch in %s at cycle %0d: expected %h, got %h",
                 name, cycle_cnt, want, got);
      end
    end
  endtask

  // monitor: check results, then predict for the item taken at this edge
  always @(posedge clk_i) begin : out_monitor
    out_item_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_MAX) begin
            $display("unexpected result at cycle %0d: %h", cycle_cnt, out_item_o);
          end
        end else begin
          want = expected_q.pop_front();
          check_field("valid_res",  want.valid_res,  out_item_o.valid_res);
          check_field("out_x",      want.out_x,      out_item_o.out_x);
          check_field("out_y",      want.out_y,      out_item_o.out_y);
          check_field("out_count",  want.out_count,  out_item_o.out_count);
          check_field("out_key",    want.out_key,    out_item_o.out_key);
          check_field("fill_level", want.fill_level, out_item_o.fill_level);
          check_field("is_empty",   want.is_empty,   out_item_o.is_empty);
          check_field("overflow",   want.overflow,   out_item_o.overflow);
        end
      end
      in_taken = in_valid_i && !in_stall_o;
      if (in_taken) begin
        expected_q.insert(expected_q.size(), queue_step(in_item_i));
      end
    end
  end

  // driver: payload holds while stalled, next item once taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (pending_q.size() > 0 && !idle_roll()) begin
          in_item_i  <= pending_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= idle_roll();
    end
  end

  task automatic add_push(logic [7:0] x, logic [7:0] y, logic [8:0] cnt, logic [31:0] key);
    in_item_t it;
    it.action       = ACT_PUSH;
    it.pos_x        = x;
    it.pos_y        = y;
    it.option_count = cnt;
    it.random_key   = key;
    pending_q.insert(pending_q.size(), it);
  endtask

  // pop carries random content in the unused fields
  task automatic add_pop();
    in_item_t it;
    it.action       = ACT_POP;
    it.pos_x        = 8'($urandom);
    it.pos_y        = 8'($urandom);
    it.option_count = 9'($urandom);
    it.random_key   = $urandom;
    pending_q.insert(pending_q.size(), it);
  endtask

  // random push; small ranges make ties on count, key and position common
  task automatic rand_push(bit allow_drop);
    logic [7:0]  x;
    logic [7:0]  y;
    logic [8:0]  cnt;
    logic [31:0] key;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (allow_drop && pick < 10) begin
      cnt = 9'($urandom_range(0, 1));
    end else if (pick < 55) begin
      cnt = 9'($urandom_range(2, 8));
    end else begin
      cnt = 9'($urandom_range(2, 256));
    end
    key = ($urandom_range(0, 99) < 30) ? $urandom_range(0, 3) : $urandom;
    x   = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
    y   = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
    add_push(x, y, cnt, key);
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    out_stall_i = 1'b0;

    // directed: empty pop, dropped counts, extremes, ties on each key level
    add_pop();
    add_push(8'h12, 8'h34, 9'd0, 32'h0000_0001);
    add_push(8'h56, 8'h78, 9'd1, 32'hffff_ffff);
    add_push(8'hff, 8'hff, 9'd256, 32'hffff_ffff);
    add_push(8'h00, 8'h00, 9'd2, 32'h0000_0000);
    add_push(8'h03, 8'h04, 9'd5, 32'h0000_0005);
    add_push(8'h03, 8'h09, 9'd5, 32'h0000_0005);
    add_push(8'h07, 8'h00, 9'd5, 32'h0000_0005);
    add_push(8'h03, 8'h04, 9'd5, 32'h0000_0005);
    add_push(8'h01, 8'h01, 9'd5, 32'h0000_0004);
    add_push(8'haa, 8'h55, 9'd255, 32'h8000_0000);
    add_push(8'h55, 8'haa, 9'd3, 32'h7fff_ffff);
    repeat (10) add_pop();

    // deep fill, a few extremes on top, then drain one past empty
    repeat (FILL_ITEMS) rand_push(1'b0);
    add_push(8'h11, 8'h22, 9'd9, 32'h0000_0009);
    add_push(8'h00, 8'h00, 9'd256, 32'h0000_0000);
    add_push(8'h33, 8'h44, 9'd1, 32'h0000_0000);
    add_pop();
    add_push(8'h00, 8'h00, 9'd2, 32'h0000_0000);
    repeat (FILL_ITEMS + 3) add_pop();

    // random mix, pushes slightly ahead so the queue stays mostly occupied
    repeat (RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 55) begin
        rand_push(1'b1);
      end else begin
        add_pop();
      end
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // wait for all items taken and all results back
    @(negedge clk_i);
    while (pending_q.size() != 0 || in_valid_i) @(negedge clk_i);
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
